// ===== sv/tilt_bump_phase_detector_defines.svh =====
// assertion macros for the tilt bump phase detector
// no dependencies; included by the top level only
`ifndef TILT_BUMP_PHASE_DETECTOR_DEFINES_SVH
`define TILT_BUMP_PHASE_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TBPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TBPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tbpd_pkg.sv =====
// shared types, constants and helpers of the tilt bump phase detector
// no dependencies; imported by every module of the block
package tbpd_pkg;

    typedef enum logic [1:0] {
        PH_NORMAL  = 2'd0,
        PH_CLIMB   = 2'd1,
        PH_DESCENT = 2'd2,
        PH_LEVEL   = 2'd3
    } phase_t;

    // register index on the config port (byte address / 4)
    typedef enum logic [2:0] {
        REG_CLIMB_ANGLE   = 3'd0,
        REG_LEVEL_BAND    = 3'd1,
        REG_TRIGGER_HOLD  = 3'd2,
        REG_LEVEL_HOLD    = 3'd3,
        REG_DESCENT_LIMIT = 3'd4,
        REG_EVENT_LIMIT   = 3'd5,
        REG_MAX_RPM       = 3'd6
    } reg_idx_t;

    localparam int ANGLE_W = 14;
    localparam int TIME_W  = 16;
    localparam int RPM_W   = 16;
    localparam int PITCH_W = 16;
    localparam int FACT_W  = 12;

    // speed factors in q10
    localparam logic signed [FACT_W-1:0] Q10_UNITY   = 12'sd1024;
    localparam logic signed [FACT_W-1:0] Q10_CLIMB   = 12'sd1331;
    localparam logic signed [FACT_W-1:0] Q10_DESCENT = 12'sd922;

    // register reset values
    localparam logic [ANGLE_W-1:0] RST_CLIMB_ANGLE   = 14'd1000;
    localparam logic [ANGLE_W-1:0] RST_LEVEL_BAND    = 14'd500;
    localparam logic [TIME_W-1:0]  RST_TRIGGER_HOLD  = 16'd100;
    localparam logic [TIME_W-1:0]  RST_LEVEL_HOLD    = 16'd1000;
    localparam logic [TIME_W-1:0]  RST_DESCENT_LIMIT = 16'd3000;
    localparam logic [TIME_W-1:0]  RST_EVENT_LIMIT   = 16'd15000;
    localparam logic [RPM_W-1:0]   RST_MAX_RPM       = 16'd300;

    typedef struct packed {
        logic [ANGLE_W-1:0] climb_angle;
        logic [ANGLE_W-1:0] level_band;
        logic [TIME_W-1:0]  trigger_hold_ms;
        logic [TIME_W-1:0]  level_hold_ms;
        logic [TIME_W-1:0]  descent_limit_ms;
        logic [TIME_W-1:0]  event_limit_ms;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [TIME_W-1:0] trigger_timer;
        logic [TIME_W-1:0] level_timer;
        logic [TIME_W-1:0] event_timer;
        logic [TIME_W-1:0] descent_timer;
        logic              negative_seen;
    } det_state_t;

    typedef struct packed {
        logic timed_out;
        logic forced_recovery;
        logic completed;
    } pulse_t;

    localparam det_state_t DET_CLEAR = '{
        phase:         PH_NORMAL,
        trigger_timer: '0,
        level_timer:   '0,
        event_timer:   '0,
        descent_timer: '0,
        negative_seen: 1'b0
    };

    // timer add that sticks at all ones
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

// ===== sv/tbpd_update.sv =====
// next-state logic of the bump detector: cancel, timeouts and phase moves
// depends on tbpd_pkg
module tbpd_update (
    input  tbpd_pkg::cfg_t                         cfg,
    input  tbpd_pkg::det_state_t                   cur,
    input  logic signed [tbpd_pkg::PITCH_W-1:0]    pitch,
    input  logic        [tbpd_pkg::TIME_W-1:0]     elapsed_ms,
    input  logic                                   cancel,
    output tbpd_pkg::det_state_t                   nxt,
    output tbpd_pkg::pulse_t                       pulses
);
    import tbpd_pkg::*;

    logic signed [PITCH_W:0] pitch_x;
    logic signed [PITCH_W:0] band_pos;
    logic signed [PITCH_W:0] band_neg;
    logic signed [PITCH_W:0] climb_x;
    logic                    at_or_below_neg;
    logic                    at_or_below_pos;
    logic                    in_band;
    logic                    above_climb;

    assign pitch_x         = {pitch[PITCH_W-1], pitch};
    assign band_pos        = signed'({{(PITCH_W+1-ANGLE_W){1'b0}}, cfg.level_band});
    assign band_neg        = -band_pos;
    assign climb_x         = signed'({{(PITCH_W+1-ANGLE_W){1'b0}}, cfg.climb_angle});
    assign at_or_below_neg = (pitch_x <= band_neg);
    assign at_or_below_pos = (pitch_x <= band_pos);
    assign in_band         = (pitch_x >= band_neg) && at_or_below_pos;
    assign above_climb     = (pitch_x >= climb_x);

    always_comb begin
        det_state_t        s;
        logic [TIME_W-1:0] ev;
        logic [TIME_W-1:0] dsc;
        logic [TIME_W-1:0] trg;
        logic [TIME_W-1:0] lvl;
        logic              neg;

        s      = cancel ? DET_CLEAR : cur;
        ev     = sat_add(s.event_timer, elapsed_ms);
        dsc    = sat_add(s.descent_timer, elapsed_ms);
        trg    = sat_add(s.trigger_timer, elapsed_ms);
        lvl    = sat_add(s.level_timer, elapsed_ms);
        neg    = s.negative_seen | at_or_below_neg;
        nxt    = s;
        pulses = '0;

        if (elapsed_ms != '0) begin
            if (s.phase != PH_NORMAL && ev >= cfg.event_limit_ms) begin
                nxt              = DET_CLEAR;
                pulses.timed_out = 1'b1;
            end else if ((s.phase == PH_DESCENT || s.phase == PH_LEVEL) &&
                         dsc >= cfg.descent_limit_ms) begin
                nxt                    = DET_CLEAR;
                pulses.forced_recovery = 1'b1;
            end else begin
                if (s.phase != PH_NORMAL) begin
                    nxt.event_timer = ev;
                end
                if (s.phase == PH_DESCENT || s.phase == PH_LEVEL) begin
                    nxt.descent_timer = dsc;
                end
                case (s.phase)
                    PH_NORMAL: begin
                        if (!above_climb) begin
                            nxt.trigger_timer = '0;
                        end else if (trg >= cfg.trigger_hold_ms) begin
                            nxt.phase         = PH_CLIMB;
                            nxt.trigger_timer = '0;
                            nxt.event_timer   = '0;
                        end else begin
                            nxt.trigger_timer = trg;
                        end
                    end
                    PH_CLIMB: begin
                        if (at_or_below_pos) begin
                            nxt.phase         = PH_DESCENT;
                            nxt.descent_timer = '0;
                            nxt.negative_seen = at_or_below_neg;
                        end
                    end
                    PH_DESCENT: begin
                        nxt.negative_seen = neg;
                        if (neg && in_band) begin
                            nxt.phase       = PH_LEVEL;
                            nxt.level_timer = '0;
                        end
                    end
                    default: begin
                        if (!in_band) begin
                            nxt.phase       = PH_DESCENT;
                            nxt.level_timer = '0;
                        end else if (lvl >= cfg.level_hold_ms) begin
                            nxt              = DET_CLEAR;
                            pulses.completed = 1'b1;
                        end else begin
                            nxt.level_timer = lvl;
                        end
                    end
                endcase
            end
        end
    end

endmodule

// ===== sv/tbpd_scale.sv =====
// target speed: base speed times the phase factor in q10, clamped to 0..max_rpm
// depends on tbpd_pkg
module tbpd_scale (
    input  tbpd_pkg::phase_t                    phase,
    input  logic signed [tbpd_pkg::RPM_W-1:0]   base_rpm,
    input  logic        [tbpd_pkg::RPM_W-1:0]   max_rpm,
    output logic        [tbpd_pkg::RPM_W-1:0]   target_rpm
);
    import tbpd_pkg::*;

    localparam int PROD_W = RPM_W + FACT_W;

    logic signed [FACT_W-1:0] factor;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-11:0]       shifted;

    always_comb begin
        case (phase)
            PH_NORMAL: factor = Q10_UNITY;
            PH_CLIMB:  factor = Q10_CLIMB;
            default:   factor = Q10_DESCENT;
        endcase
    end

    assign prod    = PROD_W'(base_rpm) * PROD_W'(factor);
    assign shifted = prod[PROD_W-1:10];

    always_comb begin
        if (prod[PROD_W-1] || prod == '0) begin
            target_rpm = '0;
        end else if (shifted > {{(PROD_W-10-RPM_W){1'b0}}, max_rpm}) begin
            target_rpm = max_rpm;
        end else begin
            target_rpm = shifted[RPM_W-1:0];
        end
    end

endmodule

// ===== sv/tilt_bump_phase_detector.sv =====
// tilt bump phase detector: an accepted word goes to the input register, then to the result register
// throughput one word per cycle unless m_ready holds the output; one input register, one result register
// the detector state is updated in the same cycle the result register loads
// reset (aresetn low, synchronous) clears phase, timers and valids
// and loads the register defaults
module tilt_bump_phase_detector (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [4:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // sample input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [tbpd_pkg::PITCH_W-1:0]  s_pitch,
    input  logic        [tbpd_pkg::TIME_W-1:0]   s_elapsed_ms,
    input  logic signed [tbpd_pkg::RPM_W-1:0]    s_base_rpm,
    input  logic                                 s_cancel,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_phase,
    output logic [tbpd_pkg::RPM_W-1:0]           m_target_rpm,
    output logic                                 m_timed_out,
    output logic                                 m_forced_recovery,
    output logic                                 m_completed
);
    import tbpd_pkg::*;

    `include "tilt_bump_phase_detector_defines.svh"

    // config registers
    cfg_t               cfg_reg;
    logic [RPM_W-1:0]   max_rpm_reg;
    reg_idx_t           reg_idx;
    logic               cfg_wr;

    // input register
    logic                       in_vld_reg;
    logic signed [PITCH_W-1:0]  pitch_reg;
    logic [TIME_W-1:0]          elapsed_reg;
    logic signed [RPM_W-1:0]    base_reg;
    logic                       cancel_reg;

    // detector state and result register
    det_state_t         state_reg;
    det_state_t         state_next;
    pulse_t             pulse_next;
    logic [RPM_W-1:0]   target_next;
    logic               out_vld_reg;
    logic               out_vld_next;
    phase_t             phase_out_reg;
    logic [RPM_W-1:0]   target_reg;
    pulse_t             pulse_reg;

    logic               advance;
    logic               take_in;

    // ------------------------------------------------------------------
    // config port: always ready, write on the access phase
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.climb_angle      <= RST_CLIMB_ANGLE;
            cfg_reg.level_band       <= RST_LEVEL_BAND;
            cfg_reg.trigger_hold_ms  <= RST_TRIGGER_HOLD;
            cfg_reg.level_hold_ms    <= RST_LEVEL_HOLD;
            cfg_reg.descent_limit_ms <= RST_DESCENT_LIMIT;
            cfg_reg.event_limit_ms   <= RST_EVENT_LIMIT;
            max_rpm_reg              <= RST_MAX_RPM;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_CLIMB_ANGLE:   cfg_reg.climb_angle      <= pwdata[ANGLE_W-1:0];
                REG_LEVEL_BAND:    cfg_reg.level_band       <= pwdata[ANGLE_W-1:0];
                REG_TRIGGER_HOLD:  cfg_reg.trigger_hold_ms  <= pwdata[TIME_W-1:0];
                REG_LEVEL_HOLD:    cfg_reg.level_hold_ms    <= pwdata[TIME_W-1:0];
                REG_DESCENT_LIMIT: cfg_reg.descent_limit_ms <= pwdata[TIME_W-1:0];
                REG_EVENT_LIMIT:   cfg_reg.event_limit_ms   <= pwdata[TIME_W-1:0];
                REG_MAX_RPM:       max_rpm_reg              <= pwdata[RPM_W-1:0];
                default:           ;  // unmapped slot, write ignored
            endcase
        end
    end

    // read back, zero extended
    always_comb begin
        unique case (reg_idx)
            REG_CLIMB_ANGLE:   prdata = 32'(cfg_reg.climb_angle);
            REG_LEVEL_BAND:    prdata = 32'(cfg_reg.level_band);
            REG_TRIGGER_HOLD:  prdata = 32'(cfg_reg.trigger_hold_ms);
            REG_LEVEL_HOLD:    prdata = 32'(cfg_reg.level_hold_ms);
            REG_DESCENT_LIMIT: prdata = 32'(cfg_reg.descent_limit_ms);
            REG_EVENT_LIMIT:   prdata = 32'(cfg_reg.event_limit_ms);
            REG_MAX_RPM:       prdata = 32'(max_rpm_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake: the input register drains into the result register
    // whenever that one is empty or being read in the same cycle
    // ------------------------------------------------------------------
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign take_in = s_valid && s_ready;

    always_comb begin
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // single-pass update: next state, event pulses, then the speed scale
    // which works on the phase after the update
    // ------------------------------------------------------------------
    tbpd_update u_update (
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .pitch      (pitch_reg),
        .elapsed_ms (elapsed_reg),
        .cancel     (cancel_reg),
        .nxt        (state_next),
        .pulses     (pulse_next)
    );

    tbpd_scale u_scale (
        .phase      (state_next.phase),
        .base_rpm   (base_reg),
        .max_rpm    (max_rpm_reg),
        .target_rpm (target_next)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= DET_CLEAR;
        end else begin
            out_vld_reg <= out_vld_next;
            if (take_in) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (take_in) begin
            pitch_reg   <= s_pitch;
            elapsed_reg <= s_elapsed_ms;
            base_reg    <= s_base_rpm;
            cancel_reg  <= s_cancel;
        end
        if (advance) begin
            phase_out_reg <= state_next.phase;
            target_reg    <= target_next;
            pulse_reg     <= pulse_next;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_phase           = phase_out_reg;
    assign m_target_rpm      = target_reg;
    assign m_timed_out       = pulse_reg.timed_out;
    assign m_forced_recovery = pulse_reg.forced_recovery;
    assign m_completed       = pulse_reg.completed;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // the three events exclude each other
    `TBPD_ASSERT_NOW(a_one_event, aclk, aresetn, m_valid, $onehot0({m_timed_out, m_forced_recovery, m_completed}), "more than one event pulse in a word")
    // every event ends the bump, so the reported phase is normal
    `TBPD_ASSERT_NOW(a_event_normal, aclk, aresetn, m_valid && (m_timed_out || m_forced_recovery || m_completed), m_phase == PH_NORMAL, "event pulse with phase not normal")
    // target never exceeds the clamp
    `TBPD_ASSERT_NOW(a_clamp, aclk, aresetn, m_valid, m_target_rpm <= max_rpm_reg, "target speed above max_rpm")
    // detector state moves only when a word passes to the result register
    `TBPD_ASSERT_NEXT(a_state_hold, aclk, aresetn, !advance, $stable(state_reg), "detector state changed without a word")

endmodule

// ===== bench/bump_check_pkg.sv =====
`timescale 1ns / 100ps
// scoreboard for the tilt bump phase detector bench: predicts one result word per sample
// word and checks the results in order; depends on tbpd_pkg for phase codes and reg indexes
package bump_check_pkg;
    import tbpd_pkg::*;

    localparam int GAIN_NORMAL  = 1024;
    localparam int GAIN_CLIMB   = 1331;
    localparam int GAIN_DESCENT = 922;

    typedef struct {
        phase_t      phase;
        logic [15:0] target_rpm;
        logic        timed_out;
        logic        forced_recovery;
        logic        completed;
    } bump_result_t;

    class bump_scoreboard;
        int climb_angle;
        int level_band;
        int trigger_hold;
        int level_hold;
        int descent_limit;
        int event_limit;
        int max_rpm;

        phase_t      phase;
        logic [15:0] trigger_ms;
        logic [15:0] level_ms;
        logic [15:0] event_ms;
        logic [15:0] descent_ms;
        bit          negative_seen;

        bump_result_t expected_q[$];
        int           errors;

        function new();
            climb_angle   = RST_CLIMB_ANGLE;
            level_band    = RST_LEVEL_BAND;
            trigger_hold  = RST_TRIGGER_HOLD;
            level_hold    = RST_LEVEL_HOLD;
            descent_limit = RST_DESCENT_LIMIT;
            event_limit   = RST_EVENT_LIMIT;
            max_rpm       = RST_MAX_RPM;
            errors        = 0;
            clear_detection();
        endfunction

        function void clear_detection();
            phase         = PH_NORMAL;
            trigger_ms    = '0;
            level_ms      = '0;
            event_ms      = '0;
            descent_ms    = '0;
            negative_seen = 1'b0;
        endfunction

        function void write_reg(int index, logic [31:0] value);
            case (index)
                REG_CLIMB_ANGLE:   climb_angle   = value[13:0];
                REG_LEVEL_BAND:    level_band    = value[13:0];
                REG_TRIGGER_HOLD:  trigger_hold  = value[15:0];
                REG_LEVEL_HOLD:    level_hold    = value[15:0];
                REG_DESCENT_LIMIT: descent_limit = value[15:0];
                REG_EVENT_LIMIT:   event_limit   = value[15:0];
                REG_MAX_RPM:       max_rpm       = value[15:0];
                default: ;
            endcase
        endfunction

        // timers stick at all ones
        function logic [15:0] clamp_add(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[16] ? 16'hffff : s[15:0];
        endfunction

        function void advance(int pitch, logic [15:0] dt,
                              output logic tmo, output logic frc, output logic cmp);
            int band;
            bit in_band;
            band    = level_band;
            in_band = (pitch >= -band) && (pitch <= band);
            tmo = 1'b0;
            frc = 1'b0;
            cmp = 1'b0;
            if (phase != PH_NORMAL) begin
                event_ms = clamp_add(event_ms, dt);
                if (event_ms >= event_limit) begin
                    clear_detection();
                    tmo = 1'b1;
                    return;
                end
            end
            if (phase == PH_DESCENT || phase == PH_LEVEL) begin
                descent_ms = clamp_add(descent_ms, dt);
                if (descent_ms >= descent_limit) begin
                    clear_detection();
                    frc = 1'b1;
                    return;
                end
            end
            case (phase)
                PH_NORMAL: begin
                    if (pitch >= climb_angle) begin
                        trigger_ms = clamp_add(trigger_ms, dt);
                        if (trigger_ms >= trigger_hold) begin
                            phase      = PH_CLIMB;
                            trigger_ms = '0;
                            event_ms   = '0;
                        end
                    end else begin
                        trigger_ms = '0;
                    end
                end
                PH_CLIMB: begin
                    if (pitch <= band) begin
                        phase         = PH_DESCENT;
                        descent_ms    = '0;
                        negative_seen = (pitch <= -band);
                    end
                end
                PH_DESCENT: begin
                    if (pitch <= -band) negative_seen = 1'b1;
                    if (negative_seen && in_band) begin
                        phase    = PH_LEVEL;
                        level_ms = '0;
                    end
                end
                default: begin
                    if (in_band) begin
                        level_ms = clamp_add(level_ms, dt);
                        if (level_ms >= level_hold) begin
                            clear_detection();
                            cmp = 1'b1;
                        end
                    end else begin
                        phase    = PH_DESCENT;
                        level_ms = '0;
                    end
                end
            endcase
        endfunction

        function void note_sample(logic signed [15:0] pitch, logic [15:0] elapsed_ms,
                                  logic signed [15:0] base_rpm, logic cancel);
            bump_result_t r;
            int factor;
            int prod;
            int speed;
            r.timed_out       = 1'b0;
            r.forced_recovery = 1'b0;
            r.completed       = 1'b0;
            if (cancel) clear_detection();
            if (elapsed_ms != 0)
                advance(pitch, elapsed_ms, r.timed_out, r.forced_recovery, r.completed);
            case (phase)
                PH_CLIMB:  factor = GAIN_CLIMB;
                PH_NORMAL: factor = GAIN_NORMAL;
                default:   factor = GAIN_DESCENT;
            endcase
            prod = int'(base_rpm) * factor;
            if (prod <= 0) begin
                speed = 0;
            end else begin
                speed = prod >>> 10;
                if (speed > max_rpm) speed = max_rpm;
            end
            r.phase      = phase;
            r.target_rpm = speed[15:0];
            expected_q.push_back(r);
        endfunction

        function void field_check(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] phase_out, logic [15:0] target_out,
                                   logic tmo, logic frc, logic cmp);
            bump_result_t want;
            if (expected_q.size() == 0) begin
                $error("result word with no sample outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            field_check("phase", want.phase, phase_out);
            field_check("target_rpm", want.target_rpm, target_out);
            field_check("timed_out", want.timed_out, tmo);
            field_check("forced_recovery", want.forced_recovery, frc);
            field_check("completed", want.completed, cmp);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// top of the tilt bump phase detector bench: clock, reset, apb register writes,
// sample and result drivers with random idling; depends on tbpd_pkg and bump_check_pkg
module tb_top;
    import tbpd_pkg::*;
    import bump_check_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int LONG_HOLD    = 300;    // receiver hold-off, long enough to back up the input
    localparam int PHASE_WORDS  = 175;
    localparam int PHASE_COUNT  = 7;
    localparam int UNMAPPED_IDX = 7;      // first index past the register list
    localparam int PITCH_MAX    = 18000;
    localparam int ANGLE_MAX    = 9000;
    localparam int TIME_MAX     = 65535;

    // clock, reset and apb side
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // sample channel
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_pitch      = '0;
    logic [15:0]        s_elapsed_ms = '0;
    logic signed [15:0] s_base_rpm   = '0;
    logic               s_cancel     = 1'b0;

    // result channel
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_phase;
    logic [15:0] m_target_rpm;
    logic        m_timed_out;
    logic        m_forced_recovery;
    logic        m_completed;

    bump_scoreboard sb = new();

    int cycles        = 0;
    int words_sent    = 0;
    int hold_requests = 0;   // bumped by the main thread, served by the receiver
    int hold_served   = 0;
    int stall_left    = 0;
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;

    tilt_bump_phase_detector uut (.*);

    always #4 aclk = ~aclk;

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // both channels are sampled on the rising edge; results are checked before the new
    // sample is noted; order is harmless, as a sample crosses the input and result registers
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result(m_phase, m_target_rpm, m_timed_out, m_forced_recovery,
                                m_completed);
            if (s_valid && s_ready)
                sb.note_sample(s_pitch, s_elapsed_ms, s_base_rpm, s_cancel);
        end
    end

    // mostly short idles, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic int pick_range(int lo, int hi);
        if (hi <= lo) return lo;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // result receiver: random stalls, plus the long hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
            stall_left = pick_idle();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // one sample word: optional idle gap, then hold valid until accepted
    // valid only drops when a gap follows, so back-to-back words keep it high
    task automatic drive_sample(int pitch, int dt, int base, bit cancel);
        int gap;
        gap = tx_idle_en ? pick_idle() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_pitch      <= 16'(pitch);
        s_elapsed_ms <= 16'(dt);
        s_base_rpm   <= 16'(base);
        s_cancel     <= cancel;
        do @(posedge aclk); while (s_ready !== 1'b1);
        words_sent++;
    endtask

    // a word aimed at a pitch, sometimes swapped for noise: zero elapsed time, a cancel,
    // or a pitch anywhere in range, half the time with an elapsed time anywhere in range
    task automatic send_shaped(int pitch, int dt_max);
        int dt;
        int r;
        bit cancel;
        cancel = 1'b0;
        dt     = pick_range(1, dt_max);
        r      = $urandom_range(0, 99);
        if (r < 4) begin
            dt = 0;
        end else if (r < 7) begin
            cancel = 1'b1;
        end else if (r < 13) begin
            pitch = pick_range(-PITCH_MAX, PITCH_MAX);
            if (r < 10) dt = $urandom_range(0, TIME_MAX);
        end
        drive_sample(pitch, dt, $urandom_range(0, 65535), cancel);
    endtask

    // one bump: lead-in below the climb angle, climb, crest, dip to or below the low band
    // edge, then settle in the band; the pitch targets follow the current register settings
    task automatic send_bump(int dt_max);
        int n;
        n = $urandom_range(0, 3);
        repeat (n) send_shaped(pick_range(-PITCH_MAX, sb.climb_angle - 1), dt_max);
        n = $urandom_range(1, 8);
        repeat (n) send_shaped(pick_range(sb.climb_angle, PITCH_MAX), dt_max);
        n = $urandom_range(0, 3);
        repeat (n) send_shaped(pick_range(sb.level_band + 1, PITCH_MAX), dt_max);
        n = $urandom_range(1, 4);
        repeat (n) send_shaped(pick_range(-PITCH_MAX, -sb.level_band), dt_max);
        n = $urandom_range(1, 30);
        repeat (n) send_shaped(pick_range(-sb.level_band, sb.level_band), dt_max);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic apb_write(int index, int value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(index * 4);
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        sb.write_reg(index, 32'(value));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_detector(int angle, int band, int trig, int lvl, int desc,
                                    int evt, int rpm);
        apb_write(REG_CLIMB_ANGLE, angle);
        apb_write(REG_LEVEL_BAND, band);
        apb_write(REG_TRIGGER_HOLD, trig);
        apb_write(REG_LEVEL_HOLD, lvl);
        apb_write(REG_DESCENT_LIMIT, desc);
        apb_write(REG_EVENT_LIMIT, evt);
        apb_write(REG_MAX_RPM, rpm);
    endtask

    // drop valid, wait for every expected word, then let the pipeline go quiet
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int dt_max;
        int first;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed run on the reset settings: angle 1000, band 500, trigger 100,
        // level 1000, descent 3000, event 15000, max rpm 300
        drive_sample(-PITCH_MAX, 0, 32767, 1'b0);     // zero elapsed, speed clamped
        drive_sample(PITCH_MAX, TIME_MAX, -32768, 1'b0); // trigger saturates, into climb
        drive_sample(PITCH_MAX, 0, 1000, 1'b0);       // zero elapsed holds climb
        drive_sample(0, 10, 200, 1'b0);               // crest into descent, no dip yet
        drive_sample(-600, 10, 200, 1'b0);            // dip below the band
        drive_sample(100, 10, 200, 1'b0);             // back in band: level hold
        drive_sample(ANGLE_MAX, 10, 200, 1'b0);       // out of band: back to descent
        drive_sample(0, 10, 200, 1'b0);               // dip still remembered: level
        drive_sample(0, 1000, 400, 1'b0);             // level hold met: completed
        drive_sample(1000, 100, 400, 1'b0);           // exactly at angle and hold
        drive_sample(-500, 1, 400, 1'b0);             // band edge from below
        drive_sample(500, 1, 400, 1'b0);              // band edge from above
        drive_sample(0, 3000, 400, 1'b0);             // descent limit: forced recovery
        drive_sample(999, 50, 0, 1'b0);               // just under the angle
        drive_sample(1000, 99, 1, 1'b0);              // one short of the trigger hold
        drive_sample(1000, 1, 1, 1'b1);               // cancel drops the partial trigger
        drive_sample(2000, 100, 1, 1'b0);             // into climb
        drive_sample(2000, 15000, 300, 1'b0);         // whole-event timeout
        drive_sample(2000, 200, 300, 1'b0);           // climb again
        drive_sample(0, 0, 300, 1'b1);                // cancel with zero elapsed
        drive_sample(2000, 200, 300, 1'b0);           // climb once more
        drive_sample(2000, TIME_MAX, 300, 1'b0);      // event timer saturates: timeout
        settle();

        for (int p = 1; p <= PHASE_COUNT; p++) begin
            case (p)
                1, 7: begin
                    // tight limits so every exit path shows up often
                    program_detector(800, 300, 40, 120, 400, 900, 5000);
                    dt_max = 40;
                end
                2: begin
                    // all zero: every limit met on its first check
                    program_detector(0, 0, 0, 0, 0, 0, 0);
                    apb_write(UNMAPPED_IDX, 32'h5a5a);
                    dt_max = 20;
                end
                3: begin
                    // everything at the top, elapsed times up to the full range
                    program_detector(ANGLE_MAX, ANGLE_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                                     TIME_MAX, TIME_MAX);
                    dt_max = TIME_MAX;
                end
                5: begin
                    program_detector(RST_CLIMB_ANGLE, RST_LEVEL_BAND, RST_TRIGGER_HOLD,
                                     RST_LEVEL_HOLD, RST_DESCENT_LIMIT, RST_EVENT_LIMIT,
                                     RST_MAX_RPM);
                    dt_max = 120;
                end
                default: begin
                    program_detector($urandom_range(0, ANGLE_MAX), $urandom_range(0, 1500),
                                     $urandom_range(0, 600), $urandom_range(0, 1500),
                                     $urandom_range(0, 3000), $urandom_range(0, 8000),
                                     $urandom_range(0, 65535));
                    dt_max = $urandom_range(5, 150);
                end
            endcase
            // one stretch with no idling on either side
            tx_idle_en = (p != 6);
            rx_idle_en = (p != 6);
            // long receiver hold-off while samples keep coming, so the input stalls
            if (p == 4) hold_requests++;
            first = words_sent;
            while (words_sent - first < PHASE_WORDS) send_bump(dt_max);
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
